FILE: src/lcr_pkg.sv
package lcr_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int CHANNEL_COUNT   = 2;
    localparam int THRESH_W        = 10;
    localparam int DUTY_W          = 8;
    localparam int COUNT_W         = 8;
    localparam int MUX_W           = 4;
    localparam int CFG_DATA_W      = 10;
    localparam int CFG_IDX_W       = 3;
    localparam int OUT_TDATA_W     = 16;
    localparam int OUT_TUSER_W     = 2;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST  = 10'd180;
    localparam logic [DUTY_W-1:0]   DUTY_STEP_RST  = 8'd1;
    localparam logic [DUTY_W-1:0]   DUTY_MAX_RST   = 8'd127;
    localparam logic [COUNT_W-1:0]  SAMPLES_RST    = 8'd10;
    localparam logic [MUX_W-1:0]    FIRST_MUX_RST  = 4'd1;
    localparam logic [MUX_W-1:0]    SECOND_MUX_RST = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD  = 3'd0,
        REG_DUTY_STEP  = 3'd1,
        REG_DUTY_MAX   = 3'd2,
        REG_SAMPLES    = 3'd3,
        REG_FIRST_MUX  = 3'd4,
        REG_SECOND_MUX = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [DUTY_W-1:0]   duty_step;
        logic [DUTY_W-1:0]   duty_max;
        logic [COUNT_W-1:0]  samples_per_decision;
        logic [MUX_W-1:0]    first_mux;
        logic [MUX_W-1:0]    second_mux;
    } cfg_t;

    typedef struct packed {
        logic               written;
        logic [DUTY_W-1:0]  level;
        logic [COUNT_W-1:0] count;
    } decision_t;

endpackage

FILE: src/lcr_cfg.sv
module lcr_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lcr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output lcr_pkg::cfg_t                       cfg
);

    lcr_pkg::cfg_t cfg_reg;
    lcr_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (lcr_pkg::cfg_index_t'(cfg_index))
                lcr_pkg::REG_THRESHOLD:  cfg_next.threshold = cfg_wdata[lcr_pkg::THRESH_W-1:0];
                lcr_pkg::REG_DUTY_STEP:  cfg_next.duty_step = cfg_wdata[lcr_pkg::DUTY_W-1:0];
                lcr_pkg::REG_DUTY_MAX:   cfg_next.duty_max  = cfg_wdata[lcr_pkg::DUTY_W-1:0];
                lcr_pkg::REG_SAMPLES:
                    cfg_next.samples_per_decision = cfg_wdata[lcr_pkg::COUNT_W-1:0];
                lcr_pkg::REG_FIRST_MUX:  cfg_next.first_mux  = cfg_wdata[lcr_pkg::MUX_W-1:0];
                lcr_pkg::REG_SECOND_MUX: cfg_next.second_mux = cfg_wdata[lcr_pkg::MUX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold            <= lcr_pkg::THRESHOLD_RST;
            cfg_reg.duty_step            <= lcr_pkg::DUTY_STEP_RST;
            cfg_reg.duty_max             <= lcr_pkg::DUTY_MAX_RST;
            cfg_reg.samples_per_decision <= lcr_pkg::SAMPLES_RST;
            cfg_reg.first_mux            <= lcr_pkg::FIRST_MUX_RST;
            cfg_reg.second_mux           <= lcr_pkg::SECOND_MUX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/lcr_calc.sv
module lcr_calc #(
    parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]          sample,
    input  logic [SAMPLE_BITS-1:0]          avg_old,
    input  logic [lcr_pkg::COUNT_W-1:0]     cnt_old,
    input  logic [lcr_pkg::DUTY_W-1:0]      lvl_old,
    input  lcr_pkg::cfg_t                   cfg,
    output logic [SAMPLE_BITS-1:0]          avg_new,
    output lcr_pkg::decision_t              dec
);

    localparam int CMP_W = (SAMPLE_BITS > lcr_pkg::THRESH_W) ? SAMPLE_BITS : lcr_pkg::THRESH_W;

    logic [SAMPLE_BITS:0]          avg_sum;
    logic [lcr_pkg::COUNT_W-1:0]   cnt_inc;
    logic [CMP_W-1:0]              avg_cmp;
    logic [CMP_W-1:0]              thr_cmp;
    logic [lcr_pkg::DUTY_W:0]      step_x2;
    logic [lcr_pkg::DUTY_W:0]      up_sum;

    assign avg_sum = {1'b0, avg_old} + {1'b0, sample};
    assign avg_new = avg_sum[SAMPLE_BITS:1];
    assign cnt_inc = cnt_old + lcr_pkg::COUNT_W'(1);
    assign avg_cmp = CMP_W'(avg_new);
    assign thr_cmp = CMP_W'(cfg.threshold);
    assign step_x2 = {1'b0, cfg.duty_step} + {1'b0, cfg.duty_step};
    assign up_sum  = {1'b0, lvl_old} + {1'b0, cfg.duty_step};

    always_comb begin
        dec.written = 1'b0;
        dec.level   = lvl_old;
        dec.count   = cnt_inc;
        if (cnt_inc >= cfg.samples_per_decision) begin
            dec.count = '0;
            // low average -> step down, floor at duty_step (no wrap)
            if (avg_cmp < thr_cmp) begin
                dec.written = 1'b1;
                if ({1'b0, lvl_old} < step_x2) begin
                    dec.level = cfg.duty_step;
                end else begin
                    dec.level = lvl_old - cfg.duty_step;
                end
            end else if (avg_cmp > thr_cmp) begin
                dec.written = 1'b1;
                if (up_sum > {1'b0, cfg.duty_max}) begin
                    dec.level = cfg.duty_max;
                end else begin
                    dec.level = up_sum[lcr_pkg::DUTY_W-1:0];
                end
            end
        end
    end

endmodule

FILE: src/dual_channel_led_current_regulator.sv
// An accepted input beat passes the input register, then the decision logic into the
// result register on m_tvalid; the result register frees as it is taken.
// Throughput: one sample per cycle while m_tready stays high.
// Reset (aresetn, synchronous, active low): channel 0 active, averages, counts
// and duty levels cleared, configuration registers back to their defaults.
module dual_channel_led_current_regulator #(
    parameter int  SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF,
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_TDATA_W-1:0]               s_tdata,   // sense_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcr_pkg::OUT_TDATA_W-1:0]     m_tdata,   // duty_value, next_mux_channel
    output logic [lcr_pkg::OUT_TUSER_W-1:0]     m_tuser,   // served_channel, duty_written
    input  logic                                cfg_wr_en,
    input  logic [lcr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    lcr_pkg::cfg_t cfg;

    logic                           in_valid_reg;
    logic [SAMPLE_BITS-1:0]         in_sample_reg;
    logic                           active_reg;
    logic [SAMPLE_BITS-1:0]         avg_reg   [lcr_pkg::CHANNEL_COUNT];
    logic [lcr_pkg::COUNT_W-1:0]    count_reg [lcr_pkg::CHANNEL_COUNT];
    logic [lcr_pkg::DUTY_W-1:0]     duty_reg  [lcr_pkg::CHANNEL_COUNT];

    logic                           m_valid_reg;
    logic                           served_reg;
    logic                           written_reg;
    logic [lcr_pkg::DUTY_W-1:0]     duty_out_reg;
    logic [lcr_pkg::MUX_W-1:0]      mux_out_reg;

    logic                           advance;
    logic                           s_beat;
    logic [SAMPLE_BITS-1:0]         avg_next;
    lcr_pkg::decision_t             dec;
    logic [lcr_pkg::MUX_W-1:0]      mux_next;

    lcr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lcr_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_calc (
        .sample  (in_sample_reg),
        .avg_old (avg_reg[active_reg]),
        .cnt_old (count_reg[active_reg]),
        .lvl_old (duty_reg[active_reg]),
        .cfg     (cfg),
        .avg_new (avg_next),
        .dec     (dec)
    );

    // input register moves on whenever the result register is free or being taken
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;
    assign mux_next = active_reg ? cfg.first_mux : cfg.second_mux;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            for (int i = 0; i < lcr_pkg::CHANNEL_COUNT; i++) begin
                avg_reg[i]   <= '0;
                count_reg[i] <= '0;
                duty_reg[i]  <= '0;
            end
        end else if (advance) begin
            active_reg            <= ~active_reg;
            avg_reg[active_reg]   <= avg_next;
            count_reg[active_reg] <= dec.count;
            duty_reg[active_reg]  <= dec.level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            served_reg   <= active_reg;
            written_reg  <= dec.written;
            duty_out_reg <= dec.level;
            mux_out_reg  <= mux_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lcr_pkg::OUT_TDATA_W - lcr_pkg::DUTY_W - lcr_pkg::MUX_W){1'b0}},
                       mux_out_reg, duty_out_reg};
    assign m_tuser  = {written_reg, served_reg};

`ifndef SYNTH
    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("result register empty after an advancing beat");

    a_channel_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (active_reg != $past(active_reg)))
        else $error("active channel did not hand over");

    a_channel_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(active_reg))
        else $error("active channel changed without a beat");

    a_decision_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && dec.written) |=> (count_reg[served_reg] == '0))
        else $error("sample count not cleared on a duty write");

    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W       = lcr_pkg::SAMPLE_BITS_DEF;
    localparam int IN_W           = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SAMPLE_TOP     = (1 << SAMPLE_W) - 1;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 62;
    localparam int MAX_GAP        = 13;
    localparam int HOLD_AT_RESULT = 150;
    localparam int HOLD_CYCLES    = 64;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic                       served;
        logic                       written;
        logic [lcr_pkg::DUTY_W-1:0] duty;
        logic [lcr_pkg::MUX_W-1:0]  mux;
    } regulation_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        lcr_pkg::cfg_index_t            reg_idx;
        logic [lcr_pkg::CFG_DATA_W-1:0] value;
        logic                           pinned;
        regulation_t                    outcome;
    } stim_row_t;

    // pinned rows: served, written, duty, next mux
    localparam stim_row_t DIRECTED [29] = '{
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd0,    1'b1, '{1'b0, 1'b0, 8'd0,   4'd3}},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd1023, 1'b1, '{1'b1, 1'b0, 8'd0,   4'd1}},
        // a zero count decides on every sample
        '{ROW_WRITE,  lcr_pkg::REG_SAMPLES,    10'd0,    1'b0, '0},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd0,    1'b1, '{1'b0, 1'b1, 8'd1,   4'd3}},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd1023, 1'b1, '{1'b1, 1'b1, 8'd1,   4'd1}},
        '{ROW_WRITE,  lcr_pkg::REG_THRESHOLD,  10'd1023, 1'b0, '0},
        '{ROW_WRITE,  lcr_pkg::REG_DUTY_STEP,  10'd255,  1'b0, '0},
        '{ROW_WRITE,  lcr_pkg::REG_DUTY_MAX,   10'd0,    1'b0, '0},
        // step down from near zero lands on the step value
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd1023, 1'b1, '{1'b0, 1'b1, 8'd255, 4'd3}},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd1023, 1'b1, '{1'b1, 1'b1, 8'd255, 4'd1}},
        '{ROW_WRITE,  lcr_pkg::REG_THRESHOLD,  10'd0,    1'b0, '0},
        // step up clamps to a max that sits below the step
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd0,    1'b1, '{1'b0, 1'b1, 8'd0,   4'd3}},
        '{ROW_WRITE,  lcr_pkg::REG_DUTY_MAX,   10'd255,  1'b0, '0},
        '{ROW_WRITE,  lcr_pkg::REG_DUTY_STEP,  10'd1,    1'b0, '0},
        // saturated at max, still flagged as written
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd0,    1'b1, '{1'b1, 1'b1, 8'd255, 4'd1}},
        '{ROW_WRITE,  lcr_pkg::REG_THRESHOLD,  10'd255,  1'b0, '0},
        // average equals threshold: no write
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd255,  1'b1, '{1'b0, 1'b0, 8'd0,   4'd3}},
        '{ROW_WRITE,  lcr_pkg::REG_FIRST_MUX,  10'd15,   1'b0, '0},
        '{ROW_WRITE,  lcr_pkg::REG_SECOND_MUX, 10'd0,    1'b0, '0},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd512,  1'b1, '{1'b1, 1'b1, 8'd255, 4'd15}},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd0,    1'b1, '{1'b0, 1'b1, 8'd1,   4'd0}},
        // build up counts, then drop the decision count to meet them
        '{ROW_WRITE,  lcr_pkg::REG_SAMPLES,    10'd200,  1'b0, '0},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'h2AA,  1'b0, '0},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'h155,  1'b0, '0},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd1000, 1'b0, '0},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd5,    1'b0, '0},
        '{ROW_WRITE,  lcr_pkg::REG_SAMPLES,    10'd2,    1'b0, '0},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd600,  1'b0, '0},
        '{ROW_SAMPLE, lcr_pkg::REG_THRESHOLD,  10'd100,  1'b0, '0}
    };

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [IN_W-1:0]                 s_tdata;    // sense_sample
    logic                            m_tvalid;
    logic                            m_tready;
    logic [lcr_pkg::OUT_TDATA_W-1:0] m_tdata;    // duty_value, next_mux_channel
    logic [lcr_pkg::OUT_TUSER_W-1:0] m_tuser;    // served_channel, duty_written
    logic                            cfg_wr_en;
    lcr_pkg::cfg_index_t             cfg_index;
    logic [lcr_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    // regulator shadow state
    lcr_pkg::cfg_t                   shadow;
    logic                            active_ch;
    logic [SAMPLE_W-1:0]             avg_q   [lcr_pkg::CHANNEL_COUNT];
    logic [lcr_pkg::COUNT_W-1:0]     count_q [lcr_pkg::CHANNEL_COUNT];
    logic [lcr_pkg::DUTY_W-1:0]      duty_q  [lcr_pkg::CHANNEL_COUNT];

    regulation_t            duty_reports_due [$];
    regulation_t            pinned_reports [int];
    int                     items_sent = 0;
    int                     results_seen = 0;
    int                     mismatches = 0;
    int                     idle_cycles = 0;

    dual_channel_led_current_regulator #(
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_report(input regulation_t want, input regulation_t got,
                                  input string tag);
        if (got.served !== want.served)
            flag_mismatch($sformatf("%s beat %0d served_channel %0b, want %0b",
                                    tag, results_seen, got.served, want.served));
        if (got.written !== want.written)
            flag_mismatch($sformatf("%s beat %0d duty_written %0b, want %0b",
                                    tag, results_seen, got.written, want.written));
        if (got.duty !== want.duty)
            flag_mismatch($sformatf("%s beat %0d duty_value %0d, want %0d",
                                    tag, results_seen, got.duty, want.duty));
        if (got.mux !== want.mux)
            flag_mismatch($sformatf("%s beat %0d next_mux_channel %0d, want %0d",
                                    tag, results_seen, got.mux, want.mux));
    endtask

    function automatic regulation_t regulate_sample(input logic [SAMPLE_W-1:0] sample);
        regulation_t                 r;
        logic                        ch;
        logic [SAMPLE_W:0]           sum;
        logic [lcr_pkg::COUNT_W-1:0] cnt;
        logic [lcr_pkg::DUTY_W:0]    lvl;
        ch = active_ch;
        sum = {1'b0, avg_q[ch]} + {1'b0, sample};
        avg_q[ch] = sum[SAMPLE_W:1];
        cnt = count_q[ch] + lcr_pkg::COUNT_W'(1);
        lvl = {1'b0, duty_q[ch]};
        r.written = 1'b0;
        if (cnt >= shadow.samples_per_decision) begin
            cnt = '0;
            if (avg_q[ch] < shadow.threshold) begin
                // floor is one step above zero, never wraps
                if (lvl < ({1'b0, shadow.duty_step} << 1))
                    lvl = {1'b0, shadow.duty_step};
                else
                    lvl = lvl - {1'b0, shadow.duty_step};
                r.written = 1'b1;
            end else if (avg_q[ch] > shadow.threshold) begin
                lvl = lvl + {1'b0, shadow.duty_step};
                if (lvl > {1'b0, shadow.duty_max})
                    lvl = {1'b0, shadow.duty_max};
                r.written = 1'b1;
            end
        end
        count_q[ch] = cnt;
        duty_q[ch] = lvl[lcr_pkg::DUTY_W-1:0];
        active_ch = ~ch;
        r.served = ch;
        r.duty = lvl[lcr_pkg::DUTY_W-1:0];
        r.mux = active_ch ? shadow.second_mux : shadow.first_mux;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample(
        input logic [lcr_pkg::THRESH_W-1:0] center);
        int v;
        case ($urandom_range(0, 7))
            0: v = $urandom_range(0, SAMPLE_TOP);
            1: v = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
            default: v = int'(center) + int'($urandom_range(0, 40)) - 20;
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_TOP)
            v = SAMPLE_TOP;
        return v[SAMPLE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        regulation_t got;
        if (!aresetn) begin
            shadow = '{lcr_pkg::THRESHOLD_RST, lcr_pkg::DUTY_STEP_RST,
                       lcr_pkg::DUTY_MAX_RST, lcr_pkg::SAMPLES_RST,
                       lcr_pkg::FIRST_MUX_RST, lcr_pkg::SECOND_MUX_RST};
            active_ch = 1'b0;
            for (int i = 0; i < lcr_pkg::CHANNEL_COUNT; i++) begin
                avg_q[i] = '0;
                count_q[i] = '0;
                duty_q[i] = '0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser[0], m_tuser[1], m_tdata[7:0], m_tdata[11:8]};
                if (duty_reports_due.size() == 0)
                    flag_mismatch($sformatf("beat %0d with no sample outstanding",
                                            results_seen));
                else
                    compare_report(duty_reports_due.pop_front(), got, "predicted");
                if (pinned_reports.exists(results_seen))
                    compare_report(pinned_reports[results_seen], got, "directed");
                results_seen++;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    lcr_pkg::REG_THRESHOLD:
                        shadow.threshold = cfg_wdata[lcr_pkg::THRESH_W-1:0];
                    lcr_pkg::REG_DUTY_STEP:
                        shadow.duty_step = cfg_wdata[lcr_pkg::DUTY_W-1:0];
                    lcr_pkg::REG_DUTY_MAX:
                        shadow.duty_max = cfg_wdata[lcr_pkg::DUTY_W-1:0];
                    lcr_pkg::REG_SAMPLES:
                        shadow.samples_per_decision = cfg_wdata[lcr_pkg::COUNT_W-1:0];
                    lcr_pkg::REG_FIRST_MUX:
                        shadow.first_mux = cfg_wdata[lcr_pkg::MUX_W-1:0];
                    lcr_pkg::REG_SECOND_MUX:
                        shadow.second_mux = cfg_wdata[lcr_pkg::MUX_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                duty_reports_due.push_back(regulate_sample(s_tdata[SAMPLE_W-1:0]));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input int gap);
        cfg_wr_en <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= IN_W'(value);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input lcr_pkg::cfg_index_t idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= lcr_pkg::CFG_DATA_W'(value);
        @(negedge aclk);
    endtask

    // quiet the input and let every outstanding beat drain before a register write
    task automatic settle();
        s_tvalid <= 1'b0;
        cfg_wr_en <= 1'b0;
        while (duty_reports_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int  stall;
        int  taken;
        bit  quiet;
        m_tready = 1'b0;
        taken = 0;
        quiet = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            // one long hold-off so the pipeline backs up into s_tready
            if (taken == HOLD_AT_RESULT)
                stall = HOLD_CYCLES;
            else
                stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
            taken++;
            if ($urandom_range(0, 23) == 0)
                quiet = !quiet;
        end
    end

    initial begin
        lcr_pkg::cfg_t setting;
        bit            sender_quiet;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = lcr_pkg::REG_THRESHOLD;
        cfg_wdata = '0;
        sender_quiet = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                settle();
                write_reg(DIRECTED[i].reg_idx, int'(DIRECTED[i].value));
            end else begin
                if (DIRECTED[i].pinned)
                    pinned_reports[items_sent] = DIRECTED[i].outcome;
                send_sample(DIRECTED[i].value[SAMPLE_W-1:0], $urandom_range(0, MAX_GAP));
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: setting = '{10'd0, 8'd255, 8'd255, 8'd255, 4'd0, 4'd15};
                1: setting = '{10'd1023, 8'd1, 8'd0, 8'd1, 4'd15, 4'd0};
                2: setting = '{lcr_pkg::THRESHOLD_RST, lcr_pkg::DUTY_STEP_RST,
                               lcr_pkg::DUTY_MAX_RST, lcr_pkg::SAMPLES_RST,
                               lcr_pkg::FIRST_MUX_RST, lcr_pkg::SECOND_MUX_RST};
                default: begin
                    setting.threshold = lcr_pkg::THRESH_W'($urandom_range(100, 900));
                    setting.duty_step = lcr_pkg::DUTY_W'(($urandom_range(0, 3) == 0) ?
                                        $urandom_range(0, 255) : $urandom_range(1, 20));
                    setting.duty_max = lcr_pkg::DUTY_W'($urandom_range(0, 255));
                    setting.samples_per_decision = lcr_pkg::COUNT_W'($urandom_range(0, 8));
                    setting.first_mux = lcr_pkg::MUX_W'($urandom_range(0, 15));
                    setting.second_mux = lcr_pkg::MUX_W'($urandom_range(0, 15));
                end
            endcase
            write_reg(lcr_pkg::REG_THRESHOLD, int'(setting.threshold));
            write_reg(lcr_pkg::REG_DUTY_STEP, int'(setting.duty_step));
            write_reg(lcr_pkg::REG_DUTY_MAX, int'(setting.duty_max));
            write_reg(lcr_pkg::REG_SAMPLES, int'(setting.samples_per_decision));
            write_reg(lcr_pkg::REG_FIRST_MUX, int'(setting.first_mux));
            write_reg(lcr_pkg::REG_SECOND_MUX, int'(setting.second_mux));
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 23) == 0)
                    sender_quiet = !sender_quiet;
                send_sample(draw_sample(setting.threshold),
                            sender_quiet ? 0 : $urandom_range(0, MAX_GAP));
            end
        end

        s_tvalid <= 1'b0;
        while (duty_reports_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
